>>> hdl/jsu_pkg.sv
// Package for the JSON string unescape block: decode modes, result kinds,
// command records between front and back end, and the hex digit decoder.
// No dependencies.
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_END  = 2'd1,
    CMD_ERR  = 2'd2,
    CMD_CODE = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] data;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  localparam logic [7:0] TERM_RESET   = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] BYTE_BS      = 8'h08;
  localparam logic [7:0] BYTE_FF      = 8'h0C;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_TAB     = 8'h09;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // Returns {valid, value} for one ASCII hex digit in either case.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/jsu_front.sv
// Front end of the JSON string unescape block: accepts raw bytes, tracks the
// escape state and pushes one command per byte that yields results.
// Depends on jsu_pkg.
`default_nettype none
module jsu_front
  import jsu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic      accept,
  input  wire logic [7:0] in_byte,
  output logic           push,
  output cmd_t           push_cmd
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  term_r;
  logic [4:0]  hex;
  logic [15:0] acc_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
      term_r <= TERM_RESET;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      if (cfg_we) begin
        term_r <= cfg_data;
      end
    end
  end

  assign hex       = hex_value(in_byte);
  assign acc_shift = {acc_r[11:0], hex[3:0]};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    push     = 1'b0;
    push_cmd = '{op: CMD_BYTE, data: {8'h00, in_byte}};
    if (accept) begin
      unique case (mode_r)
        MODE_ESCAPE: begin
          mode_nxt = MODE_NORMAL;
          push     = 1'b1;
          unique case (in_byte)
            CH_BACKSLASH, CH_QUOTE, CH_SLASH: push_cmd.data = {8'h00, in_byte};
            CH_B: push_cmd.data = {8'h00, BYTE_BS};
            CH_F: push_cmd.data = {8'h00, BYTE_FF};
            CH_N: push_cmd.data = {8'h00, BYTE_LF};
            CH_R: push_cmd.data = {8'h00, BYTE_CR};
            CH_T: push_cmd.data = {8'h00, BYTE_TAB};
            CH_U: begin
              push     = 1'b0;
              mode_nxt = MODE_HEX0;
              acc_nxt  = '0;
            end
            default: push = 1'b0;
          endcase
        end
        MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
          if (!hex[4]) begin
            mode_nxt = MODE_NORMAL;
            acc_nxt  = '0;
            push     = 1'b1;
            push_cmd = '{op: CMD_ERR, data: 16'h0000};
          end else if (mode_r == MODE_HEX3) begin
            mode_nxt = MODE_NORMAL;
            acc_nxt  = '0;
            push     = 1'b1;
            push_cmd = '{op: CMD_CODE, data: acc_shift};
          end else begin
            acc_nxt = acc_shift;
            unique case (mode_r)
              MODE_HEX0: mode_nxt = MODE_HEX1;
              MODE_HEX1: mode_nxt = MODE_HEX2;
              default:   mode_nxt = MODE_HEX3;
            endcase
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          if (in_byte == CH_BACKSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else if (in_byte == term_r) begin
            push     = 1'b1;
            push_cmd = '{op: CMD_END, data: 16'h0000};
          end else begin
            push = 1'b1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/jsu_queue.sv
// Short command queue between front and back end of the unescape block.
// Depends on jsu_pkg.
`default_nettype none
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign head             = entries_r[rd_ptr_r];
  assign status.not_empty = (count_r != '0);
  assign status.full      = (count_r == FULL_CNT);

endmodule
`default_nettype wire

>>> hdl/jsu_back.sv
// Back end of the unescape block: expands queued commands into result items,
// one per cycle unless stalled, into the output register. Depends on jsu_pkg.
`default_nettype none
module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  cmd_t            head,
  input  q_status_t       status,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_last
);

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic [1:0] kind_r;
  logic       last_r;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] last_idx;
  logic [7:0] sel_byte;
  logic [1:0] sel_kind;
  logic       load, is_last;
  logic [15:0] code;

  assign code = head.data;
  assign load = status.not_empty && (!out_valid_r || !out_stall);

  always_comb begin
    last_idx = 2'd0;
    sel_byte = code[7:0];
    sel_kind = KIND_DATA;
    unique case (head.op)
      CMD_END: begin
        sel_byte = 8'h00;
        sel_kind = KIND_END;
      end
      CMD_ERR: begin
        sel_byte = 8'h00;
        sel_kind = KIND_ERROR;
      end
      CMD_CODE: begin
        if (code[15:7] == '0) begin
          sel_byte = code[7:0];
        end else if (code[15:11] == '0) begin
          last_idx = 2'd1;
          sel_byte = (idx_r == 2'd0) ? (UTF8_LEAD2 | {3'b000, code[10:6]})
                                     : (UTF8_CONT | {2'b00, code[5:0]});
        end else begin
          last_idx = 2'd2;
          unique case (idx_r)
            2'd0:    sel_byte = UTF8_LEAD3 | {4'h0, code[15:12]};
            2'd1:    sel_byte = UTF8_CONT | {2'b00, code[11:6]};
            default: sel_byte = UTF8_CONT | {2'b00, code[5:0]};
          endcase
        end
      end
      default: sel_byte = code[7:0];
    endcase
  end

  assign is_last = (idx_r == last_idx);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      kind_r <= sel_kind;
      last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

>>> hdl/json_string_unescape_top.sv
// Top level of the JSON string unescape block: front end, command queue and
// back end. Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// The block takes one byte of a JSON string body per cycle unless in_stall is
// high and hands out one result item per cycle unless out_stall holds it. The
// first result of a byte is written into a queue entry and from there loaded
// into the output register. Each result-producing byte becomes one command in a
// queue of QUEUE_DEPTH entries; the back end hands out the results of a command
// one at a time, so a u escape for a three-byte UTF-8 sequence yields three
// result items from its six input bytes. Input is stalled only when the queue
// is full, which happens when the output side stalls for long.
`default_nettype none
module json_string_unescape_top
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_last
);

  logic      accept, push, pop;
  cmd_t      push_cmd, head;
  q_status_t status;

  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_byte  (in_byte),
    .push     (push),
    .push_cmd (push_cmd)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("command pushed into a full queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> status.not_empty)
    else $error("command popped from an empty queue");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> (out_last && out_byte == 8'h00))
    else $error("end or error item without last flag or with nonzero byte");

  a_new_item_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(status.not_empty))
    else $error("result item appeared without a queued command");

endmodule
`default_nettype wire

>>> bench/json_string_unescape_top_tb.sv
// Testbench for json_string_unescape_top: drives escaped JSON string bytes
// with random bursts and output stalls, and checks every result item against
// a scoreboard that decodes the same bytes. Depends on jsu_pkg and the RTL.
`timescale 1ns / 1ps

module json_string_unescape_top_tb;
  import jsu_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 74;
  localparam int HOLD_CYCLES  = 80;

  localparam logic [7:0] ESC_LETTERS [8] = '{CH_BACKSLASH, CH_QUOTE, CH_SLASH,
                                             CH_B, CH_F, CH_N, CH_R, CH_T};

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic       is_last;
  } decoded_t;

  class unescape_scoreboard;
    mode_t       mode;
    logic [15:0] accum;
    logic [7:0]  terminator;
    decoded_t    awaited[$];
    int          errors;

    function new();
      mode       = MODE_NORMAL;
      accum      = 16'h0000;
      terminator = TERM_RESET;
      errors     = 0;
    endfunction

    static function int digit_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
    endfunction

    function void set_terminator(logic [7:0] v);
      terminator = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void push(logic [7:0] data, logic [1:0] kind, logic is_last);
      decoded_t r;
      r.data    = data;
      r.kind    = kind;
      r.is_last = is_last;
      awaited.insert(awaited.size(), r);
    endfunction

    function void emit_code(logic [15:0] code);
      if (code < 16'h0080) begin
        push(code[7:0], KIND_DATA, 1'b1);
      end else if (code < 16'h0800) begin
        push(UTF8_LEAD2 | {3'b000, code[10:6]}, KIND_DATA, 1'b0);
        push(UTF8_CONT | {2'b00, code[5:0]}, KIND_DATA, 1'b1);
      end else begin
        push(UTF8_LEAD3 | {4'b0000, code[15:12]}, KIND_DATA, 1'b0);
        push(UTF8_CONT | {2'b00, code[11:6]}, KIND_DATA, 1'b0);
        push(UTF8_CONT | {2'b00, code[5:0]}, KIND_DATA, 1'b1);
      end
    endfunction

    function void note_input(logic [7:0] c);
      int          d;
      logic [15:0] code;
      case (mode)
        MODE_ESCAPE: begin
          mode = MODE_NORMAL;
          case (c)
            CH_BACKSLASH, CH_QUOTE, CH_SLASH: push(c, KIND_DATA, 1'b1);
            CH_B: push(BYTE_BS, KIND_DATA, 1'b1);
            CH_F: push(BYTE_FF, KIND_DATA, 1'b1);
            CH_N: push(BYTE_LF, KIND_DATA, 1'b1);
            CH_R: push(BYTE_CR, KIND_DATA, 1'b1);
            CH_T: push(BYTE_TAB, KIND_DATA, 1'b1);
            CH_U: begin
              mode  = MODE_HEX0;
              accum = 16'h0000;
            end
            default: ;
          endcase
        end
        MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
          d = digit_value(c);
          if (d < 0) begin
            mode  = MODE_NORMAL;
            accum = 16'h0000;
            push(8'h00, KIND_ERROR, 1'b1);
          end else begin
            accum = {accum[11:0], d[3:0]};
            if (mode != MODE_HEX3) begin
              mode = mode_t'(mode + 3'd1);
            end else begin
              code  = accum;
              accum = 16'h0000;
              mode  = MODE_NORMAL;
              emit_code(code);
            end
          end
        end
        default: begin
          mode = MODE_NORMAL;
          if (c == CH_BACKSLASH) begin
            mode = MODE_ESCAPE;
          end else if (c == terminator) begin
            push(8'h00, KIND_END, 1'b1);
          end else begin
            push(c, KIND_DATA, 1'b1);
          end
        end
      endcase
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] kind, logic is_last);
      decoded_t w;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual byte %0h kind %0d last %0b",
                 $time, data, kind, is_last);
        return;
      end
      w = awaited.pop_front();
      if (data !== w.data) report("out_byte", w.data, data);
      if (kind !== w.kind) report("out_kind", w.kind, kind);
      if (is_last !== w.is_last) report("out_last", w.is_last, is_last);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  unescape_scoreboard sb;
  int  cycle_count;
  int  burst_left;
  int  hold_left;
  int  stall_pct;
  int  epoch_left;
  int  bytes_sent;
  bit  hold_req;

  json_string_unescape_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_byte);
      if (out_valid && !out_stall) sb.check_result(out_byte, out_kind, out_last);
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (epoch_left == 0) begin
        epoch_left = $urandom_range(20, 60);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      epoch_left--;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_byte  <= 8'($urandom_range(255));
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_terminator(input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_terminator(v);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  function automatic bit is_escape_letter(logic [7:0] c);
    foreach (ESC_LETTERS[i]) if (ESC_LETTERS[i] == c) return 1'b1;
    return c == CH_U;
  endfunction

  task automatic send_code(input logic [15:0] code);
    send_byte(CH_BACKSLASH);
    send_byte(CH_U);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(code[i*4 +: 4], 1'($urandom_range(1))));
  endtask

  task automatic send_token();
    int          r;
    int          pos;
    logic [7:0]  b;
    logic [15:0] code;
    r = $urandom_range(99);
    if (r < 35) begin
      b = 8'($urandom_range(255));
      if (b == CH_BACKSLASH) b = 8'h61;
      send_byte(b);
    end else if (r < 50) begin
      send_byte(CH_BACKSLASH);
      send_byte(ESC_LETTERS[$urandom_range(7)]);
    end else if (r < 72) begin
      case ($urandom_range(3))
        0: code = 16'($urandom_range(16'h007F));
        1: code = 16'($urandom_range(16'h07FF, 16'h0080));
        2: code = 16'($urandom_range(16'hFFFF, 16'h0800));
        default: begin
          case ($urandom_range(5))
            0: code = 16'h0000;
            1: code = 16'h007F;
            2: code = 16'h0080;
            3: code = 16'h07FF;
            4: code = 16'h0800;
            default: code = 16'hFFFF;
          endcase
        end
      endcase
      send_code(code);
    end else if (r < 80) begin
      pos = $urandom_range(3);
      send_byte(CH_BACKSLASH);
      send_byte(CH_U);
      for (int i = 0; i < pos; i++) begin
        send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
      end
      do b = 8'($urandom_range(255)); while (unescape_scoreboard::digit_value(b) >= 0);
      send_byte(b);
    end else if (r < 85) begin
      do b = 8'($urandom_range(255)); while (is_escape_letter(b));
      send_byte(CH_BACKSLASH);
      send_byte(b);
    end else if (r < 92) begin
      send_byte(sb.terminator);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    logic [7:0] phase_term[5];
    int         start_count;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_data    = 8'h00;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    out_stall   = 1'b0;
    cycle_count = 0;
    burst_left  = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    stall_pct   = 0;
    epoch_left  = 0;
    bytes_sent  = 0;
    sb          = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default terminator first: byte extremes, escapes (including an escaped
    // terminator and an unknown letter), u escapes of each length, a bad hex
    // digit and the end of the string.
    directed = '{8'h00, 8'hFF, CH_BACKSLASH, CH_BACKSLASH, CH_BACKSLASH, CH_QUOTE,
                 CH_BACKSLASH, CH_N, CH_BACKSLASH, 8'h71,
                 CH_BACKSLASH, CH_U, 8'h30, 8'h37, 8'h66, 8'h46,
                 CH_BACKSLASH, CH_U, 8'h44, 8'h78, CH_QUOTE};
    foreach (directed[i]) send_byte(directed[i]);
    send_code(16'hFFFF);
    send_code(16'h0041);
    wait_drained();

    phase_term = '{8'h00, 8'hFF, CH_BACKSLASH, 8'h00, TERM_RESET};
    phase_term[3] = 8'($urandom_range(255));
    for (int p = 0; p < 5; p++) begin
      write_terminator(phase_term[p]);
      if (p == 1 || p == 3) hold_req = 1'b1;
      start_count = bytes_sent;
      while (bytes_sent - start_count < PHASE_ITEMS) begin
        send_token();
      end
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_top.sv
bench/json_string_unescape_top_tb.sv
